>>> rtl/pmtd_pkg.sv
// ---------------------------------------------------------------------------
// pmtd_pkg
// Types, widths and tables shared by the telemetry decoder modules.
// ---------------------------------------------------------------------------
package pmtd_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int OUT_W  = 48;   // result field width
  localparam int NUM_W  = 43;   // magnitude of the direct-format numerator
  localparam int DEN_W  = 42;   // direct-format divisor
  localparam int P10_W  = 27;   // holds 10^8
  localparam int Q_DEPTH = 8;   // front-to-back queue entries
  localparam int Q_AW   = $clog2(Q_DEPTH);

  localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG_MAG = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic {
    FUNC_LINEAR11 = 1'b0,
    FUNC_DIRECT   = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    CFG_COEF_M = 2'd0,
    CFG_COEF_B = 2'd1,
    CFG_COEF_R = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic        func;
    logic [15:0] raw_word;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value_q16;
    logic                    saturated;
    logic                    div_error;
  } result_t;

  // classified item handed from front to back
  typedef struct packed {
    logic             is_lin;
    logic [OUT_W-1:0] lin_val;
    logic             lin_sat;
    logic             err;
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } work_t;

  typedef struct packed {
    work_t            w;
    logic             ovf;
    logic [DEN_W-1:0] rem;
    logic [OUT_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [1:0] inflight;
  } front_sts_t;

  function automatic logic [P10_W-1:0] pow10(input logic [3:0] idx);
    logic [P10_W-1:0] p;
    unique case (idx)
      4'd0:    p = P10_W'(1);
      4'd1:    p = P10_W'(10);
      4'd2:    p = P10_W'(100);
      4'd3:    p = P10_W'(1000);
      4'd4:    p = P10_W'(10000);
      4'd5:    p = P10_W'(100000);
      4'd6:    p = P10_W'(1000000);
      4'd7:    p = P10_W'(10000000);
      4'd8:    p = P10_W'(100000000);
      default: p = P10_W'(1);
    endcase
    return p;
  endfunction

endpackage

>>> rtl/pmtd_front.sv
// ---------------------------------------------------------------------------
// pmtd_front
// Accepts items, decodes LINEAR11 in full and forms numerator and divisor
// for the direct format over three stages.
// ---------------------------------------------------------------------------
module pmtd_front import pmtd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  item_t              item_i,
  input  logic signed [15:0] coef_m_i,
  input  logic signed [15:0] coef_b_i,
  input  logic signed [4:0]  coef_r_i,
  output logic               out_valid_o,
  output work_t              out_o,
  output front_sts_t         sts_o
);

  // stage A
  logic               a_valid_q;
  logic               a_is_lin_q, a_lin_sat_q, a_rneg_q, a_mzero_q, a_mneg_q;
  logic [OUT_W-1:0]   a_lin_val_q;
  logic [15:0]        a_word_q, a_mabs_q;
  logic signed [15:0] a_b_q;
  logic [3:0]         a_pidx_q;
  // stage B
  logic               b_valid_q;
  logic               b_is_lin_q, b_lin_sat_q, b_mzero_q, b_mneg_q;
  logic [OUT_W-1:0]   b_lin_val_q;
  logic signed [NUM_W-1:0] b_mb_q;
  logic [NUM_W-1:0]   b_mw_q;
  logic [DEN_W-1:0]   b_den_q;
  // stage C
  logic               c_valid_q;
  work_t              c_q;

  logic               y_neg;
  logic [11:0]        y_mag;
  logic signed [6:0]  sh;
  logic [6:0]         sh_neg;
  logic [63:0]        lin_mag;
  logic               lin_sat;
  logic [OUT_W-1:0]   lin_val;
  logic signed [4:0]  r_cl;
  logic [4:0]         r_abs;

  always_comb begin
    y_neg  = item_i.raw_word[10];
    y_mag  = y_neg ? (12'h000 - {1'b1, item_i.raw_word[10:0]})
                   : {1'b0, item_i.raw_word[10:0]};
    sh     = $signed({{2{item_i.raw_word[15]}}, item_i.raw_word[15:11]})
             + 7'(FRAC_BITS);
    sh_neg = 7'h00 - sh;
    if (!sh[6]) begin
      lin_mag = 64'(y_mag) << sh[5:0];
    end else begin
      lin_mag = 64'(y_mag) >> sh_neg[5:0];
    end
    if (y_neg) begin
      lin_sat = lin_mag > 64'(NEG_MAG);
      lin_val = lin_sat ? NEG_MAG : (OUT_W'(0) - lin_mag[OUT_W-1:0]);
    end else begin
      lin_sat = lin_mag > 64'(POS_MAX);
      lin_val = lin_sat ? POS_MAX : lin_mag[OUT_W-1:0];
    end
    if (coef_r_i < -5'sd8) begin
      r_cl = -5'sd8;
    end else if (coef_r_i > 5'sd8) begin
      r_cl = 5'sd8;
    end else begin
      r_cl = coef_r_i;
    end
    r_abs = r_cl[4] ? (5'd0 - r_cl) : r_cl;
  end

  // stage B: scale by 10^|R| on the side that R selects
  logic [P10_W-1:0]        p10, f_b, f_w;
  logic signed [NUM_W:0]   mul_b;
  logic [NUM_W-1:0]        mul_w, mul_d;

  always_comb begin
    p10   = pow10(a_pidx_q);
    f_b   = a_rneg_q ? P10_W'(1) : p10;
    f_w   = a_rneg_q ? p10 : P10_W'(1);
    mul_b = $signed(a_b_q) * $signed({1'b0, f_b});
    mul_w = a_word_q * f_w;
    mul_d = a_mabs_q * f_b;
  end

  // stage C: numerator = word*fw - b*fb, split into sign and magnitude
  logic signed [NUM_W+1:0] num;
  logic [NUM_W+1:0]        num_abs;

  always_comb begin
    num     = $signed({2'b00, b_mw_q}) - $signed({{2{b_mb_q[NUM_W-1]}}, b_mb_q});
    num_abs = num[NUM_W+1] ? ((NUM_W+2)'(0) - num) : num;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= take_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_is_lin_q  <= (item_i.func == FUNC_LINEAR11);
    a_lin_val_q <= lin_val;
    a_lin_sat_q <= lin_sat;
    a_word_q    <= item_i.raw_word;
    a_b_q       <= coef_b_i;
    a_pidx_q    <= r_abs[3:0];
    a_rneg_q    <= r_cl[4];
    a_mzero_q   <= (coef_m_i == 16'sd0);
    a_mneg_q    <= coef_m_i[15];
    a_mabs_q    <= coef_m_i[15] ? (16'h0000 - coef_m_i) : coef_m_i;

    b_is_lin_q  <= a_is_lin_q;
    b_lin_val_q <= a_lin_val_q;
    b_lin_sat_q <= a_lin_sat_q;
    b_mzero_q   <= a_mzero_q;
    b_mneg_q    <= a_mneg_q;
    b_mb_q      <= mul_b[NUM_W-1:0];
    b_mw_q      <= mul_w;
    b_den_q     <= mul_d[DEN_W-1:0];

    c_q.is_lin  <= b_is_lin_q;
    c_q.lin_val <= b_lin_val_q;
    c_q.lin_sat <= b_lin_sat_q;
    c_q.err     <= b_mzero_q;
    c_q.neg     <= num[NUM_W+1] ^ b_mneg_q;
    c_q.num     <= num_abs[NUM_W-1:0];
    c_q.den     <= b_den_q;
  end

  assign out_valid_o    = c_valid_q;
  assign out_o          = c_q;
  assign sts_o.inflight = 2'({1'b0, a_valid_q} + {1'b0, b_valid_q} + {1'b0, c_valid_q});

endmodule

>>> rtl/pmtd_queue.sv
// ---------------------------------------------------------------------------
// pmtd_queue
// Short FIFO between front and back; it pops an item to the back whenever it holds one.
// ---------------------------------------------------------------------------
module pmtd_queue import pmtd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  work_t         data_i,
  output logic          valid_o,
  output work_t         data_o,
  output logic [Q_AW:0] count_o
);

  work_t           mem_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_q, rd_q;
  logic [Q_AW:0]   cnt_q;
  logic            pop;
  logic            valid_q;
  work_t           data_q;

  assign pop = (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop)    rd_q <= rd_q + 1'b1;
      cnt_q   <= cnt_q + (Q_AW+1)'(push_i) - (Q_AW+1)'(pop);
      valid_q <= pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (pop) data_q <= mem_q[rd_q];
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign count_o = cnt_q;

endmodule

>>> rtl/pmtd_back.sv
// ---------------------------------------------------------------------------
// pmtd_back
// Pipelined restoring divider, one quotient bit per stage, then sign,
// saturation and format selection into the result register.
// ---------------------------------------------------------------------------
module pmtd_back import pmtd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  work_t   in_i,
  output logic    valid_o,
  output result_t result_o
);

  localparam int SH = OUT_W - FRAC_BITS;

  logic  vld_q [OUT_W+1];
  div_t  stg_q [OUT_W+1];

  // pre-stage: top part of num*2^F above bit OUT_W decides overflow
  logic [NUM_W-1:0] top;
  logic             ovf;

  always_comb begin
    top = in_i.num >> SH;
    ovf = top >= {1'b0, in_i.den};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q[0].w   <= in_i;
    stg_q[0].ovf <= ovf;
    stg_q[0].rem <= ovf ? '0 : top[DEN_W-1:0];
    stg_q[0].quo <= '0;
  end

  for (genvar j = 0; j < OUT_W; j++) begin : g_div
    localparam int K = OUT_W - 1 - j;
    logic           dbit;
    logic [DEN_W:0] t;
    div_t           nxt;

    if (K >= FRAC_BITS) begin : g_bit
      assign dbit = stg_q[j].w.num[K-FRAC_BITS];
    end else begin : g_zero
      assign dbit = 1'b0;
    end

    always_comb begin
      nxt = stg_q[j];
      t   = {stg_q[j].rem, dbit};
      if (t >= {1'b0, stg_q[j].w.den}) begin
        nxt.rem    = DEN_W'(t - {1'b0, stg_q[j].w.den});
        nxt.quo[K] = 1'b1;
      end else begin
        nxt.rem = t[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      stg_q[j+1] <= nxt;
    end
  end

  // result
  div_t    fin;
  result_t res_d, res_q;
  logic    valid_q;

  always_comb begin
    fin   = stg_q[OUT_W];
    res_d = '0;
    priority if (fin.w.is_lin) begin
      res_d.value_q16 = fin.w.lin_val;
      res_d.saturated = fin.w.lin_sat;
    end else if (fin.w.err) begin
      res_d.div_error = 1'b1;
    end else if (fin.w.neg) begin
      res_d.saturated = fin.ovf || (fin.quo > NEG_MAG);
      res_d.value_q16 = res_d.saturated ? NEG_MAG : (OUT_W'(0) - fin.quo);
    end else begin
      res_d.saturated = fin.ovf || (fin.quo > POS_MAX);
      res_d.value_q16 = res_d.saturated ? POS_MAX : fin.quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vld_q[OUT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

>>> rtl/pmbus_telemetry_decoder.sv
// Throughput: one item per cycle; the 48-stage divider pipeline sets the depth.
// busy never rises in practice: the queue is deeper than the front can fill.
// Reset clears all valid flags and the queue and loads m=1, b=0, R=2.
// Results cannot be held off by the receiver.
// ---------------------------------------------------------------------------
// pmbus_telemetry_decoder
// LINEAR11 and DIRECT format telemetry decode to signed fixed point.
// ---------------------------------------------------------------------------
module pmbus_telemetry_decoder import pmtd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  item_t       item_i,
  output logic        valid_o,
  output result_t     result_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int LAT = 55;

  logic signed [15:0] coef_m_q, coef_b_q;
  logic signed [4:0]  coef_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_m_q <= 16'sd1;
      coef_b_q <= 16'sd0;
      coef_r_q <= 5'sd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COEF_M: coef_m_q <= cfg_wdata_i;
        CFG_COEF_B: coef_b_q <= cfg_wdata_i;
        CFG_COEF_R: coef_r_q <= cfg_wdata_i[4:0];
        default:    ;
      endcase
    end
  end

  logic          take;
  logic          f_valid, q_valid;
  work_t         f_data, q_data;
  front_sts_t    f_sts;
  logic [Q_AW:0] q_count;

  assign take = start && !busy;
  assign busy = ((Q_AW+1)'(f_sts.inflight) + q_count) >= (Q_AW+1)'(Q_DEPTH);

  pmtd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .item_i      (item_i),
    .coef_m_i    (coef_m_q),
    .coef_b_i    (coef_b_q),
    .coef_r_i    (coef_r_q),
    .out_valid_o (f_valid),
    .out_o       (f_data),
    .sts_o       (f_sts)
  );

  pmtd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_data),
    .valid_o (q_valid),
    .data_o  (q_data),
    .count_o (q_count)
  );

  pmtd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (q_valid),
    .in_i       (q_data),
    .valid_o    (valid_o),
    .result_o   (result_o)
  );

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(take, LAT))
    else $error("result without matching item");

  a_div_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_o.div_error |-> !result_o.saturated && result_o.value_q16 == '0)
    else $error("div_error with non-zero result");

  a_lin_noerr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(take && item_i.func == FUNC_LINEAR11, LAT) |-> !result_o.div_error)
    else $error("div_error on LINEAR11 item");
`endif

endmodule
